[rtl/hbw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat watchdog package
// Shared types, widths and codes for the heartbeat watchdog block.
// ----------------------------------------------------------------------------
package hbw_pkg;

    localparam int CHANNELS          = 3;
    localparam int NUM_DEADLINE_REGS = 3;

    localparam int TICK_W    = 32;
    localparam int CHAN_W    = 3;
    localparam int MASK_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [TICK_W-1:0] DEADLINE_LONG_RESET  = 32'd15000;
    localparam logic [TICK_W-1:0] DEADLINE_SHORT_RESET = 32'd4000;

    // Request kinds carried on the input tuser.
    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE_CHAN0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE_CHAN1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE_CHAN2 = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [CHAN_W-1:0] channel;
        logic [TICK_W-1:0] cur_tick;
    } hbw_item_t;

    function automatic logic [TICK_W-1:0] deadline_reset(input int idx);
        logic [TICK_W-1:0] value;
        value = DEADLINE_LONG_RESET;
        if (idx == int'(CFG_DEADLINE_CHAN1))
        begin
            value = DEADLINE_SHORT_RESET;
        end
        return value;
    endfunction

endpackage

[rtl/task_heartbeat_watchdog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task heartbeat watchdog
// Tracks heartbeat reports of three client channels and answers expiry checks.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries requests. tuser selects the kind: a heartbeat
//   report stores the request's tick as the channel's alive time and marks it
//   seen; a report for channel three or above is dropped. An expiry check
//   returns one result on the output stream: a mask of channels that were
//   never seen or whose wrapping elapsed time exceeds their deadline, and
//   feed_watchdog, set when the mask is zero. Reports produce no result.
//   Deadlines are written through cfg_we / cfg_index / cfg_data while idle;
//   an index beyond the last register is ignored.
//   Throughput is one request per cycle while no check waits on a stalled
//   receiver. A check result passes the input register and then the result
//   register, which loads when free; the compare between them is combinational.
//   Reset clears all alive times and seen flags and restores the default
//   deadlines. When the receiver stalls, the result register holds, the input
//   register still accepts one more request, and reports keep flowing until a
//   check reaches the input register and waits there for the result slot.
// ----------------------------------------------------------------------------
module task_heartbeat_watchdog
    import hbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // channel[2:0], cur_tick[34:3], zero pad
    input  logic                 s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // late_mask[2:0], feed_watchdog[3], zero pad
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    logic              item_valid;
    hbw_item_t         item;
    logic              advance;
    logic [MASK_W-1:0] late_mask;

    hbw_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    hbw_chan_state u_chan_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .late_mask  (late_mask)
    );

    hbw_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .late_mask     (late_mask),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[rtl/hbw_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat watchdog input stage
// Registers one request from the input stream and holds it until it moves on.
// ----------------------------------------------------------------------------
module hbw_in_stage
    import hbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // channel[2:0], cur_tick[34:3], zero pad
    input  logic                 s_axis_tuser,  // req_type
    input  logic                 advance,
    output logic                 item_valid,
    output hbw_item_t            item
);

    logic      valid_reg;
    logic      valid_next;
    hbw_item_t item_reg;
    logic      take;

    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.req_type <= s_axis_tuser;
            item_reg.channel  <= s_axis_tdata[CHAN_W-1:0];
            item_reg.cur_tick <= s_axis_tdata[CHAN_W +: TICK_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/hbw_chan_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat watchdog channel state
// Deadline registers, per-channel alive times and seen flags, and the
// parallel elapsed-time compare that forms the expiry mask.
// ----------------------------------------------------------------------------
module hbw_chan_state
    import hbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    input  logic                 item_valid,
    input  hbw_item_t            item,
    output logic [MASK_W-1:0]    late_mask
);

    logic [TICK_W-1:0] deadline_reg [NUM_DEADLINE_REGS];
    logic [MASK_W-1:0] mask_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DEADLINE_REGS; i++)
            begin
                deadline_reg[i] <= deadline_reset(i);
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < NUM_DEADLINE_REGS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    deadline_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Reports never wait, so a report in the input stage is applied right away.
    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_chan
        logic              hit;
        logic [TICK_W-1:0] alive_reg;
        logic              seen_reg;
        logic [TICK_W-1:0] elapsed;

        assign hit = item_valid && (item.req_type == REQ_REPORT)
                     && (item.channel == CHAN_W'(ch));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                alive_reg <= '0;
                seen_reg  <= 1'b0;
            end
            else if (hit)
            begin
                alive_reg <= item.cur_tick;
                seen_reg  <= 1'b1;
            end
        end

        // Elapsed time wraps modulo 2^32 by the width of the subtraction.
        assign elapsed        = item.cur_tick - alive_reg;
        assign mask_next[ch]  = !seen_reg || (elapsed > deadline_reg[ch]);
    end

    // Mask bits above the last channel stay clear.
    for (genvar b = CHANNELS; b < MASK_W; b++)
    begin : g_unused
        assign mask_next[b] = 1'b0;
    end

    assign late_mask = mask_next;

endmodule

[rtl/hbw_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat watchdog output stage
// Result register for check requests and the flow control back to the input.
// ----------------------------------------------------------------------------
module hbw_out_stage
    import hbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  hbw_item_t            item,
    input  logic [MASK_W-1:0]    late_mask,
    output logic                 advance,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // late_mask[2:0], feed_watchdog[3], zero pad
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MASK_W-1:0] mask_reg;
    logic              feed_reg;
    logic              out_free;
    logic              is_check;
    logic              load;

    assign is_check = item.req_type == REQ_CHECK;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load     = item_valid && is_check && out_free;
    // A report leaves no result and so never waits on the output side.
    assign advance  = item_valid && (!is_check || out_free);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mask_reg <= late_mask;
            feed_reg <= (late_mask == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-MASK_W-1)'(0), feed_reg, mask_reg};

endmodule

[rtl/hbw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat watchdog checker
// Port-level assertions on the heartbeat watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module hbw_checker
    import hbw_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic check_taken;

    assign check_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_CHECK);

    // The feed flag must agree with the mask it travels with.
    a_feed_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[MASK_W] == (m_axis_tdata[MASK_W-1:0] == '0)))
        else $error("feed_watchdog disagrees with the expiry mask");

    // A result appearing on an empty output comes from a check request taken at the input.
    a_result_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(check_taken, 2))
        else $error("result without a matching check request");

    // A stalled result stays put.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Unused padding of the result stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:MASK_W+1] == '0))
        else $error("result padding not zero");

endmodule

bind task_heartbeat_watchdog hbw_checker u_hbw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat watchdog testbench
// Streams heartbeat reports and expiry checks into the watchdog under several
// deadline settings, predicts every expiry mask in a scoreboard and compares
// each result as it leaves the block, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import hbw_pkg::*;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_CHANNEL   = (1 << CHAN_W) - 1;

    // Index past the last deadline register; writes there must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              feed;
    } hbw_verdict_t;

    class heartbeat_tracker;
        logic [TICK_W-1:0] deadline [NUM_DEADLINE_REGS];
        logic [TICK_W-1:0] alive_time [CHANNELS];
        logic              seen [CHANNELS];
        hbw_verdict_t      verdicts_due [$];
        int errors;
        int reports;
        int dropped;
        int checks;
        int results;

        function new();
            deadline[CFG_DEADLINE_CHAN0] = DEADLINE_LONG_RESET;
            deadline[CFG_DEADLINE_CHAN1] = DEADLINE_SHORT_RESET;
            deadline[CFG_DEADLINE_CHAN2] = DEADLINE_LONG_RESET;
            for (int c = 0; c < CHANNELS; c++)
            begin
                alive_time[c] = '0;
                seen[c]       = 1'b0;
            end
        endfunction

        function void write_deadline(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] value);
            if (idx < NUM_DEADLINE_REGS)
            begin
                deadline[idx] = value;
            end
        endfunction

        function logic [MASK_W-1:0] expired_channels(logic [TICK_W-1:0] now);
            logic [MASK_W-1:0] mask;
            logic [TICK_W-1:0] elapsed;
            mask = '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                // Elapsed time wraps, so a tick before the alive time looks very late.
                elapsed = now - alive_time[c];
                if (!seen[c] || elapsed > deadline[c])
                begin
                    mask[c] = 1'b1;
                end
            end
            return mask;
        endfunction

        function void note_request(hbw_item_t item);
            hbw_verdict_t v;
            if (item.req_type == REQ_REPORT)
            begin
                if (item.channel < CHANNELS)
                begin
                    alive_time[item.channel] = item.cur_tick;
                    seen[item.channel]       = 1'b1;
                    reports++;
                end
                else
                begin
                    dropped++;
                end
            end
            else
            begin
                v.mask = expired_channels(item.cur_tick);
                v.feed = (v.mask == '0);
                verdicts_due.push_back(v);
                checks++;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] data);
            hbw_verdict_t want;
            results++;
            if (verdicts_due.size() == 0)
            begin
                report_mismatch($sformatf("result %02h arrived with no check pending", data));
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (data[MASK_W-1:0] !== want.mask)
                begin
                    report_mismatch($sformatf("late_mask %b, expected %b",
                                              data[MASK_W-1:0], want.mask));
                end
                if (data[MASK_W] !== want.feed)
                begin
                    report_mismatch($sformatf("feed_watchdog %b, expected %b",
                                              data[MASK_W], want.feed));
                end
            end
        endtask

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // channel[2:0], cur_tick[34:3], zero pad
    logic                 s_axis_tuser;   // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // late_mask[2:0], feed_watchdog[3], zero pad
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    heartbeat_tracker tracker = new();
    bit               idle_on;
    int               settings_used;
    int               quiet_cycles;

    task_heartbeat_watchdog uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tracker.check_result(m_axis_tdata);
        end
    end

    // Ends the run when no request moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task send_request(logic rt, logic [CHAN_W-1:0] ch, logic [TICK_W-1:0] tk);
        hbw_item_t item;
        item = '{req_type: rt, channel: ch, cur_tick: tk};
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rt;
        s_axis_tdata  <= {{(S_TDATA_W - TICK_W - CHAN_W){1'b0}}, tk, ch};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        tracker.note_request(item);
    endtask

    // Reports leave no result behind, so wait out a settle period after the last pending result.
    task drain_requests();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task load_deadlines(logic [TICK_W-1:0] d0, logic [TICK_W-1:0] d1,
                        logic [TICK_W-1:0] d2);
        logic [TICK_W-1:0] values [NUM_DEADLINE_REGS + 1];
        values[CFG_DEADLINE_CHAN0] = d0;
        values[CFG_DEADLINE_CHAN1] = d1;
        values[CFG_DEADLINE_CHAN2] = d2;
        values[CFG_UNUSED_INDEX]   = $urandom;
        for (int i = 0; i <= NUM_DEADLINE_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
            tracker.write_deadline(CFG_IDX_W'(i), values[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task run_random(int count, logic [TICK_W-1:0] start_tick, bit allow_idle);
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] tk;
        int                pick;
        int                c;
        now = start_tick;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
            begin
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            end
            now  = now + TICK_W'($urandom_range(0, 3000));
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_request(REQ_REPORT, CHAN_W'($urandom_range(0, CHANNELS - 1)), now);
            end
            else if (pick < 65)
            begin
                send_request(REQ_CHECK, CHAN_W'($urandom_range(0, MAX_CHANNEL)), now);
            end
            else if (pick < 80)
            begin
                // Aim right at one channel's deadline edge: one tick early, on it, or late.
                c  = $urandom_range(0, CHANNELS - 1);
                tk = tracker.alive_time[c] + tracker.deadline[c]
                     + TICK_W'($urandom_range(0, 2)) - TICK_W'(1);
                send_request(REQ_CHECK, CHAN_W'($urandom_range(0, MAX_CHANNEL)), tk);
            end
            else if (pick < 90)
            begin
                send_request(REQ_REPORT, CHAN_W'($urandom_range(CHANNELS, MAX_CHANNEL)),
                             $urandom);
            end
            else
            begin
                send_request(1'($urandom_range(0, 1)), CHAN_W'($urandom_range(0, MAX_CHANNEL)),
                             $urandom);
            end
        end
        drain_requests();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= REQ_REPORT;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_DEADLINE_CHAN0;
        cfg_data      <= '0;
        idle_on        = 1'b1;
        settings_used  = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset deadlines. Nothing has been seen yet.
        send_request(REQ_CHECK, 3'd0, 32'd0);
        send_request(REQ_REPORT, 3'd3, 32'd5);
        send_request(REQ_REPORT, 3'd7, 32'hFFFF_FFFF);
        send_request(REQ_CHECK, 3'd0, 32'd1);
        send_request(REQ_REPORT, 3'd0, 32'd0);
        send_request(REQ_REPORT, 3'd1, 32'd100);
        send_request(REQ_REPORT, 3'd2, 32'd200);
        // Exactly on the short deadline, then one tick past it; channel field is noise.
        send_request(REQ_CHECK, 3'd5, 32'd4100);
        send_request(REQ_CHECK, 3'd7, 32'd4101);
        send_request(REQ_CHECK, 3'd2, 32'd15000);
        send_request(REQ_CHECK, 3'd6, 32'd15001);
        send_request(REQ_CHECK, 3'd1, 32'hFFFF_FFFF);
        send_request(REQ_REPORT, 3'd0, 32'hFFFF_FFFF);
        send_request(REQ_REPORT, 3'd1, 32'hFFFF_FF00);
        send_request(REQ_REPORT, 3'd2, 32'hFFFF_F000);
        send_request(REQ_CHECK, 3'd0, 32'd0);
        // A tick just before channel zero's alive time reads as a huge elapsed time.
        send_request(REQ_CHECK, 3'd3, 32'hFFFF_FFF0);
        send_request(REQ_REPORT, 3'd4, 32'h1234_5678);
        send_request(REQ_REPORT, 3'd5, 32'hAAAA_5555);
        send_request(REQ_REPORT, 3'd6, 32'h5555_AAAA);
        send_request(REQ_CHECK, 3'd4, 32'd0);
        drain_requests();

        run_random(250, 32'd0, 1'b1);

        load_deadlines(32'd0, 32'hFFFF_FFFF, 32'd1);
        send_request(REQ_CHECK, 3'd0, tracker.alive_time[0]);
        send_request(REQ_CHECK, 3'd0, tracker.alive_time[0] + 32'd1);
        run_random(200, 32'h0010_0000, 1'b1);

        load_deadlines(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE);
        run_random(200, 32'h7FFF_F000, 1'b1);

        load_deadlines($urandom_range(0, 5000), $urandom_range(0, 5000),
                       $urandom_range(0, 5000));
        run_random(250, $urandom, 1'b1);

        load_deadlines($urandom, $urandom, $urandom);
        run_random(200, 32'hFFFF_0000, 1'b1);

        // Last stretch runs back to back with no gaps or stalls.
        load_deadlines(32'd100, 32'd200, 32'd300);
        run_random(250, $urandom, 1'b0);

        $display("Sent %0d heartbeat reports, %0d reports to unused channels, %0d expiry checks",
                 tracker.reports, tracker.dropped, tracker.checks);
        $display("Compared %0d results across %0d deadline settings, %0d mismatches",
                 tracker.results, settings_used, tracker.errors);
        if (tracker.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
